@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/tbsm_pkg.sv @@
package tbsm_pkg;

  // Widths and counts
  localparam int BLOCK_ID_BITS = 32;
  localparam int ID_W          = 32;
  localparam int LIMIT_W       = 16;
  localparam int ELAPSED_W     = 17;
  localparam int NUM_SLOTS     = 3;
  localparam int KIND_W        = 3;
  localparam int STATUS_W      = 3;
  localparam int SLOT_W        = 2;

  localparam logic [LIMIT_W-1:0] WAIT_LIMIT_RST = LIMIT_W'(100);

  // Stored block ids keep only BLOCK_ID_BITS bits
  localparam logic [ID_W-1:0] BLOCK_MASK =
    (BLOCK_ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((64'd1 << BLOCK_ID_BITS) - 64'd1);

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [ID_W-1:0]   load_tag_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACQ_LOAD    = 3'd0,
    KIND_MARK_LOADED = 3'd1,
    KIND_ACQ_COMPUTE = 3'd2,
    KIND_REL_COMPUTE = 3'd3,
    KIND_ROTATE      = 3'd4,
    KIND_TICK        = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 3'd0,
    STAT_GRANTED   = 3'd1,
    STAT_NO_EMPTY  = 3'd2,
    STAT_WAITING   = 3'd3,
    STAT_EMERGENCY = 3'd4,
    STAT_BUSY      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY     = 2'd0,
    SLOT_LOADING   = 2'd1,
    SLOT_READY     = 2'd2,
    SLOT_COMPUTING = 2'd3
  } slot_st_t;

  localparam slot_idx_t COMPUTE_IDX_RST = 2'd0;
  localparam slot_idx_t READY_IDX_RST   = 2'd1;
  localparam slot_idx_t LOADING_IDX_RST = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    load_tag_t         load_tag;
  } req_t;

  typedef struct packed {
    status_t   status;
    slot_idx_t slot;
    load_tag_t slot_block;
    logic      ready_available;
  } res_t;

  // Out-of-range slot numbers fold to slot 0
  function automatic slot_idx_t fix_idx(input slot_idx_t i);
    return (i < slot_idx_t'(NUM_SLOTS)) ? i : slot_idx_t'(0);
  endfunction

endpackage

@@ src/tbsm_if.sv @@
// Request channel
interface tbsm_in_if;
  import tbsm_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ID_W-1:0]     load_tag;
  modport source (output valid, output kind, output load_tag, input ready);
  modport sink   (input valid, input kind, input load_tag, output ready);
endinterface

// Result channel
interface tbsm_out_if;
  import tbsm_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [ID_W-1:0]     slot_block;
  logic                ready_available;
  modport source (output valid, output status, output slot, output slot_block,
                  output ready_available, input ready);
  modport sink   (input valid, input status, input slot, input slot_block,
                  input ready_available, output ready);
endinterface

// Configuration write channel
interface tbsm_cfg_if;
  import tbsm_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] wait_limit;
  modport source (output valid, output wait_limit, input ready);
  modport sink   (input valid, input wait_limit, output ready);
endinterface

@@ src/tbsm_in_stage.sv @@
module tbsm_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  tbsm_in_if.sink       in_ch,
  input  logic          adv,
  output logic          vld,
  output tbsm_pkg::req_t req
);
  import tbsm_pkg::*;

  logic vld_r;
  req_t req_r;

  // Take a new beat whenever the held one moves on or the stage is empty
  assign in_ch.ready = !vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req_r.kind     <= in_ch.kind;
      req_r.load_tag <= in_ch.load_tag;
    end
  end

  assign vld = vld_r;
  assign req = req_r;

endmodule

@@ src/tbsm_slot_core.sv @@
module tbsm_slot_core (
  input  logic           clk,
  input  logic           rst_n,
  tbsm_cfg_if.sink       cfg_ch,
  input  logic           go,
  input  tbsm_pkg::req_t req,
  output tbsm_pkg::res_t res
);
  import tbsm_pkg::*;

  logic [LIMIT_W-1:0]   limit_r;
  slot_st_t             st_r    [NUM_SLOTS];
  slot_st_t             st_nxt  [NUM_SLOTS];
  load_tag_t            blk_r   [NUM_SLOTS];
  load_tag_t            blk_nxt [NUM_SLOTS];
  slot_idx_t            ci_r, ci_nxt;
  slot_idx_t            ri_r, ri_nxt;
  slot_idx_t            li_r, li_nxt;
  logic                 wp_r, wp_nxt;
  logic [ELAPSED_W-1:0] we_r, we_nxt;

  logic                 empty_found;
  slot_idx_t            empty_idx;
  slot_idx_t            emerg_idx;
  slot_idx_t            rdy;
  slot_idx_t            cmp;
  logic                 rdy_ok;
  logic [ELAPSED_W-1:0] we_inc;
  status_t              rep_status;
  slot_idx_t            rep_slot;
  slot_idx_t            rep_fix;
  logic                 rep_valid;

  // Configuration register, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= WAIT_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      limit_r <= cfg_ch.wait_limit;
    end
  end

  // Slot searches over the current state
  always_comb begin
    empty_found = 1'b0;
    empty_idx   = slot_idx_t'(0);
    emerg_idx   = fix_idx(ci_r);
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (st_r[i] == SLOT_EMPTY) begin
        empty_found = 1'b1;
        empty_idx   = slot_idx_t'(i);
      end
      if (st_r[i] != SLOT_COMPUTING) begin
        emerg_idx = slot_idx_t'(i);
      end
    end
  end

  assign rdy    = fix_idx(ri_r);
  assign cmp    = fix_idx(ci_r);
  assign rdy_ok = (st_r[rdy] == SLOT_READY);
  assign we_inc = (we_r == {ELAPSED_W{1'b1}}) ? we_r : we_r + ELAPSED_W'(1);

  // Request decode and next state
  always_comb begin
    st_nxt     = st_r;
    blk_nxt    = blk_r;
    ci_nxt     = ci_r;
    ri_nxt     = ri_r;
    li_nxt     = li_r;
    wp_nxt     = wp_r;
    we_nxt     = we_r;
    rep_status = STAT_DONE;
    rep_slot   = ci_r;
    rep_valid  = 1'b1;
    case (req.kind)
      KIND_ACQ_LOAD: begin
        if (empty_found) begin
          st_nxt[empty_idx]  = SLOT_LOADING;
          blk_nxt[empty_idx] = req.load_tag & BLOCK_MASK;
          li_nxt             = empty_idx;
          rep_status         = STAT_GRANTED;
          rep_slot           = empty_idx;
        end else begin
          rep_status = STAT_NO_EMPTY;
          rep_valid  = 1'b0;
        end
      end
      KIND_MARK_LOADED: begin
        if (st_r[fix_idx(li_r)] == SLOT_LOADING) begin
          st_nxt[fix_idx(li_r)] = SLOT_READY;
        end
        rep_slot = fix_idx(li_r);
      end
      KIND_ACQ_COMPUTE: begin
        if (wp_r) begin
          rep_status = STAT_BUSY;
        end else if (rdy_ok) begin
          st_nxt[rdy] = SLOT_COMPUTING;
          ci_nxt      = rdy;
          rep_status  = STAT_GRANTED;
          rep_slot    = rdy;
        end else begin
          wp_nxt     = 1'b1;
          we_nxt     = '0;
          rep_status = STAT_WAITING;
          rep_slot   = ri_r;
        end
      end
      KIND_REL_COMPUTE: begin
        if (st_r[cmp] == SLOT_COMPUTING) begin
          st_nxt[cmp]  = SLOT_EMPTY;
          blk_nxt[cmp] = '0;
        end
        rep_slot = cmp;
      end
      KIND_ROTATE: begin
        if (st_r[cmp] == SLOT_COMPUTING) begin
          st_nxt[cmp] = SLOT_EMPTY;
        end
        ci_nxt   = rdy;
        ri_nxt   = fix_idx(li_r);
        li_nxt   = cmp;
        rep_slot = rdy;
      end
      KIND_TICK: begin
        if (wp_r) begin
          we_nxt = we_inc;
          if (rdy_ok) begin
            st_nxt[rdy] = SLOT_COMPUTING;
            ci_nxt      = rdy;
            wp_nxt      = 1'b0;
            rep_status  = STAT_GRANTED;
            rep_slot    = rdy;
          end else if (we_inc > ELAPSED_W'(limit_r)) begin
            wp_nxt     = 1'b0;
            rep_status = STAT_EMERGENCY;
            rep_slot   = emerg_idx;
          end else begin
            rep_status = STAT_WAITING;
            rep_slot   = ri_r;
          end
        end
      end
      default: begin
        rep_status = STAT_DONE;
      end
    endcase
  end

  // Result as seen after the update
  assign rep_fix             = fix_idx(rep_slot);
  assign res.status          = rep_status;
  assign res.slot            = rep_valid ? rep_fix : slot_idx_t'(0);
  assign res.slot_block      = rep_valid ? blk_nxt[rep_fix] : '0;
  assign res.ready_available = (st_nxt[fix_idx(ri_nxt)] == SLOT_READY);

  // State registers, updated once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st_r[i]  <= SLOT_EMPTY;
        blk_r[i] <= '0;
      end
      ci_r <= COMPUTE_IDX_RST;
      ri_r <= READY_IDX_RST;
      li_r <= LOADING_IDX_RST;
      wp_r <= 1'b0;
      we_r <= '0;
    end else if (go) begin
      st_r  <= st_nxt;
      blk_r <= blk_nxt;
      ci_r  <= ci_nxt;
      ri_r  <= ri_nxt;
      li_r  <= li_nxt;
      wp_r  <= wp_nxt;
      we_r  <= we_nxt;
    end
  end

endmodule

@@ src/tbsm_out_stage.sv @@
module tbsm_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  tbsm_pkg::res_t res,
  output logic           free,
  tbsm_out_if.source     out_ch
);
  import tbsm_pkg::*;

  logic out_vld_r;
  res_t res_r;

  // Register can take a beat when empty or being drained this cycle
  assign free = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (free) begin
      out_vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.status          = res_r.status;
  assign out_ch.slot            = res_r.slot;
  assign out_ch.slot_block      = res_r.slot_block;
  assign out_ch.ready_available = res_r.ready_available;

endmodule

@@ src/triple_buffer_slot_manager_core.sv @@
// Triple-buffer slot manager: three buffer slots, each empty, loading,
// ready or computing, with compute, ready and loading indices.
// in_ch carries one request per beat (kind, load_tag); out_ch returns
// exactly one result beat per request, in order (status, slot,
// slot_block, ready_available). cfg_ch writes wait_limit and is always
// ready.
// A request accepted on in_ch is held in the input register and processed
// when the result register can take it; its result is valid from then on.
// Throughput: one request per cycle while out_ch drains; the slot update is
// a single pass over the three slots between the input and result registers.
// Reset (rst_n low, synchronous): all slots empty with block id 0,
// compute/ready/loading indices 0/1/2, no pending wait, wait_limit 100.
// When out_ch stalls, the result is held and the input register keeps one
// more beat; in_ch.ready drops only while both are full and out_ch.ready
// is low.
module triple_buffer_slot_manager_core (
  input  logic       clk,
  input  logic       rst_n,
  tbsm_in_if.sink    in_ch,
  tbsm_cfg_if.sink   cfg_ch,
  tbsm_out_if.source out_ch
);
  import tbsm_pkg::*;
  `include "assert_macros.svh"

  logic s1_vld;
  req_t s1_req;
  res_t core_res;
  logic out_free;
  logic adv;

  // Held request moves on when the result register can take it
  assign adv = s1_vld && out_free;

  tbsm_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .vld   (s1_vld),
    .req   (s1_req)
  );

  tbsm_slot_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .go     (adv),
    .req    (s1_req),
    .res    (core_res)
  );

  tbsm_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (adv),
    .res    (core_res),
    .free   (out_free),
    .out_ch (out_ch)
  );

  // A draining sink never back-pressures the request side
  `AST_IMP(a_no_bubble, clk, rst_n, out_ch.ready, in_ch.ready)
  // An accepted beat passes through the input register into the result register when not stalled
  `AST_NXT(a_latency, clk, rst_n, (in_ch.valid && in_ch.ready) ##1 out_ch.ready, out_ch.valid)
  // Reported slot numbers stay in range
  `AST_IMP(a_slot_range, clk, rst_n, out_ch.valid, out_ch.slot != 2'd3)
  // A failed load reports no slot
  `AST_IMP(a_no_empty_zero, clk, rst_n, out_ch.valid && (out_ch.status == STAT_NO_EMPTY), (out_ch.slot == 2'd0) && (out_ch.slot_block == '0))

endmodule

@@ verif/slot_manager_checker.sv @@
module slot_manager_checker (
  input  logic clk,
  input  logic rst_n,
  tbsm_in_if   in_mon,
  tbsm_out_if  out_mon,
  tbsm_cfg_if  cfg_mon,
  output int   mismatches,
  output int   expected_left
);
  import tbsm_pkg::*;

  // Shadow copy of the slot manager state
  slot_st_t             slot_st [NUM_SLOTS];
  load_tag_t            slot_id [NUM_SLOTS];
  slot_idx_t            cmp_idx;
  slot_idx_t            rdy_idx;
  slot_idx_t            load_idx;
  logic                 waiting;
  logic [ELAPSED_W-1:0] ticks;
  logic [LIMIT_W-1:0]   limit;

  // Results predicted for accepted requests, oldest first
  res_t awaited_results[$];

  // Hand the ready slot to compute if it holds a loaded block
  function automatic logic grant_ready_slot();
    if (slot_st[rdy_idx] != SLOT_READY) return 1'b0;
    slot_st[rdy_idx] = SLOT_COMPUTING;
    cmp_idx = rdy_idx;
    return 1'b1;
  endfunction

  // Apply one request to the shadow state and build the result it yields
  function automatic res_t predict_slot_result(input logic [KIND_W-1:0] k,
                                               input load_tag_t id);
    res_t      r;
    status_t   st;
    slot_idx_t s;
    slot_idx_t old_cmp;
    logic      reported;
    logic      found;
    int        i;
    st = STAT_DONE;
    s = cmp_idx;
    reported = 1'b1;
    case (k)
      KIND_ACQ_LOAD: begin
        st = STAT_NO_EMPTY;
        reported = 1'b0;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (!reported && slot_st[i] == SLOT_EMPTY) begin
            slot_st[i] = SLOT_LOADING;
            slot_id[i] = id & BLOCK_MASK;
            load_idx = slot_idx_t'(i);
            s = slot_idx_t'(i);
            st = STAT_GRANTED;
            reported = 1'b1;
          end
        end
      end
      KIND_MARK_LOADED: begin
        if (slot_st[load_idx] == SLOT_LOADING) slot_st[load_idx] = SLOT_READY;
        s = load_idx;
      end
      KIND_ACQ_COMPUTE: begin
        if (waiting) begin
          st = STAT_BUSY;
        end else if (grant_ready_slot()) begin
          st = STAT_GRANTED;
          s = cmp_idx;
        end else begin
          waiting = 1'b1;
          ticks = '0;
          st = STAT_WAITING;
          s = rdy_idx;
        end
      end
      KIND_REL_COMPUTE: begin
        if (slot_st[cmp_idx] == SLOT_COMPUTING) begin
          slot_st[cmp_idx] = SLOT_EMPTY;
          slot_id[cmp_idx] = '0;
        end
      end
      KIND_ROTATE: begin
        // block id of the dropped compute slot is kept
        old_cmp = cmp_idx;
        if (slot_st[cmp_idx] == SLOT_COMPUTING) slot_st[cmp_idx] = SLOT_EMPTY;
        cmp_idx = rdy_idx;
        rdy_idx = load_idx;
        load_idx = old_cmp;
        s = cmp_idx;
      end
      KIND_TICK: begin
        if (waiting) begin
          if (ticks != '1) ticks = ticks + 1'b1;
          if (grant_ready_slot()) begin
            waiting = 1'b0;
            st = STAT_GRANTED;
            s = cmp_idx;
          end else if (ticks > {1'b0, limit}) begin
            // emergency slot: lowest one not computing, else the compute slot
            found = 1'b0;
            for (i = 0; i < NUM_SLOTS; i++) begin
              if (!found && slot_st[i] != SLOT_COMPUTING) begin
                s = slot_idx_t'(i);
                found = 1'b1;
              end
            end
            waiting = 1'b0;
            st = STAT_EMERGENCY;
          end else begin
            st = STAT_WAITING;
            s = rdy_idx;
          end
        end
      end
      default: ;
    endcase
    r.status = st;
    r.slot = reported ? s : '0;
    r.slot_block = reported ? slot_id[s] : '0;
    r.ready_available = (slot_st[rdy_idx] == SLOT_READY);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [ID_W-1:0] want,
                             input logic [ID_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    int   i;
    if (!rst_n) begin
      for (i = 0; i < NUM_SLOTS; i++) begin
        slot_st[i] = SLOT_EMPTY;
        slot_id[i] = '0;
      end
      cmp_idx = COMPUTE_IDX_RST;
      rdy_idx = READY_IDX_RST;
      load_idx = LOADING_IDX_RST;
      waiting = 1'b0;
      ticks = '0;
      limit = WAIT_LIMIT_RST;
      awaited_results.delete();
    end else begin
      // Result beat against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got status %0d slot %0d",
                   $time, out_mon.status, out_mon.slot);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", ID_W'(want.status), ID_W'(out_mon.status));
          check_field("slot", ID_W'(want.slot), ID_W'(out_mon.slot));
          check_field("slot_block", want.slot_block, out_mon.slot_block);
          check_field("ready_available", ID_W'(want.ready_available),
                      ID_W'(out_mon.ready_available));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) limit = cfg_mon.wait_limit;
      // Request beat
      if (in_mon.valid && in_mon.ready)
        awaited_results.push_back(predict_slot_result(in_mon.kind, in_mon.load_tag));
    end
    expected_left = awaited_results.size();
  end

endmodule

@@ verif/tb.sv @@
module tb;
  import tbsm_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_ITEMS = 140;
  localparam int MAX_IDLE    = 14;
  // kind codes the block leaves unused
  localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
  // ticks spent waiting under the largest wait limit
  localparam int LIMIT_MAX_TICKS = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic no_idle = 1'b0;
  int   sent_items;
  int   cycles;
  int   mismatches;
  int   expected_left;

  tbsm_in_if  in_ch ();
  tbsm_out_if out_ch ();
  tbsm_cfg_if cfg_ch ();

  triple_buffer_slot_manager_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  slot_manager_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .mismatches    (mismatches),
    .expected_left (expected_left)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_left);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stall before each beat
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // One request beat; valid stays high when the next beat follows at once
  task automatic push_request(input logic [KIND_W-1:0] k, input load_tag_t id = '0);
    int gap;
    gap = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= k;
    in_ch.load_tag <= id;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  // Stop requests and let every outstanding result come back
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_wait_limit(input logic [LIMIT_W-1:0] val);
    drain();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.wait_limit <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly load/consume cycles with random ids, some stray requests
  task automatic random_phase(input logic [LIMIT_W-1:0] val);
    int stop;
    set_wait_limit(val);
    stop = sent_items + PHASE_ITEMS;
    while (sent_items < stop) begin
      no_idle = ($urandom_range(5, 0) == 0);
      if ($urandom_range(9, 0) < 7) begin
        push_request(KIND_ACQ_LOAD, $urandom());
        push_request(KIND_MARK_LOADED, $urandom());
        if ($urandom_range(1, 0) == 1) push_request(KIND_ROTATE, $urandom());
        push_request(KIND_ACQ_COMPUTE, $urandom());
        repeat ($urandom_range(5, 0)) push_request(KIND_TICK, $urandom());
        case ($urandom_range(2, 0))
          0: push_request(KIND_REL_COMPUTE, $urandom());
          1: push_request(KIND_ROTATE, $urandom());
          default: ;
        endcase
      end else begin
        push_request(KIND_W'($urandom_range(KIND_RSVD_HI, KIND_ACQ_LOAD)), $urandom());
      end
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_ACQ_LOAD;
    in_ch.load_tag    = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.wait_limit = WAIT_LIMIT_RST;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset wait limit, busy reject, full slots, grant on tick
    push_request(KIND_TICK);
    push_request(KIND_ACQ_COMPUTE);
    push_request(KIND_ACQ_COMPUTE);
    push_request(KIND_TICK);
    push_request(KIND_ACQ_LOAD, '1);
    push_request(KIND_ACQ_LOAD, '0);
    push_request(KIND_ACQ_LOAD, 32'hA5A5_5A5A);
    push_request(KIND_ACQ_LOAD, 32'h5A5A_A5A5);
    push_request(KIND_MARK_LOADED);
    push_request(KIND_MARK_LOADED);
    push_request(KIND_ROTATE);
    push_request(KIND_TICK);
    push_request(KIND_REL_COMPUTE);
    push_request(KIND_REL_COMPUTE);
    push_request(KIND_RSVD_LO, '1);
    push_request(KIND_RSVD_HI, '1);
    push_request(KIND_ACQ_COMPUTE);

    // Zero limit: first tick of a wait takes the emergency slot
    set_wait_limit('0);
    push_request(KIND_TICK);
    push_request(KIND_MARK_LOADED);
    push_request(KIND_ROTATE);
    push_request(KIND_ACQ_COMPUTE);
    push_request(KIND_ACQ_COMPUTE);
    push_request(KIND_TICK);
    push_request(KIND_ROTATE);

    // Largest limit: a wait keeps going tick after tick
    set_wait_limit(LIMIT_MAX);
    no_idle = 1'b1;
    push_request(KIND_ACQ_COMPUTE);
    repeat (LIMIT_MAX_TICKS) push_request(KIND_TICK);

    random_phase(16'd1);
    random_phase('0);
    random_phase(16'd3);
    random_phase(LIMIT_W'($urandom_range(15, 0)));
    random_phase(LIMIT_W'($urandom_range(LIMIT_MAX, 0)));
    random_phase(16'd2);

    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && expected_left == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ triple_buffer_slot_manager_core.f @@
+incdir+src
src/tbsm_pkg.sv
src/tbsm_if.sv
src/tbsm_in_stage.sv
src/tbsm_slot_core.sv
src/tbsm_out_stage.sv
src/triple_buffer_slot_manager_core.sv
verif/slot_manager_checker.sv
verif/tb.sv
